// ----- hw/rtl/lsb_pkg.sv -----
// types, codes and pattern tables shared by the led strobe and button controller
`timescale 1ns / 1ps

package lsb_pkg;

	// input action codes
	localparam logic [1:0] ACT_TICK    = 2'd0;
	localparam logic [1:0] ACT_PRESS   = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;
	localparam logic [1:0] ACT_DONE    = 2'd3;

	// button numbers
	localparam logic [1:0] BTN_LEFT  = 2'd1;
	localparam logic [1:0] BTN_RIGHT = 2'd2;

	// configuration register indexes
	localparam int         CFG_IDX_W      = 2;
	localparam int         CFG_DATA_W     = 12;
	localparam logic [1:0] CFG_HOLD_TICKS = 2'd0;
	localparam logic [1:0] CFG_LEVEL_HIGH = 2'd1;
	localparam logic [1:0] CFG_LEVEL_MID  = 2'd2;
	localparam logic [1:0] CFG_LEVEL_LOW  = 2'd3;

	// configuration reset values
	localparam logic [11:0] HOLD_TICKS_RST = 12'd1500;
	localparam logic [7:0]  LEVEL_HIGH_RST = 8'hFF;
	localparam logic [7:0]  LEVEL_MID_RST  = 8'h40;
	localparam logic [7:0]  LEVEL_LOW_RST  = 8'h01;

	// brightness and pattern indexes
	localparam logic [1:0] BRIGHT_HIGH  = 2'd0;
	localparam logic [1:0] BRIGHT_MID   = 2'd1;
	localparam logic [1:0] BRIGHT_LAST  = 2'd2;
	localparam logic [2:0] PATTERN_LAST = 3'd5;

	// counter limits
	localparam logic [11:0] HOLD_MAX   = 12'hFFF;
	localparam logic [9:0]  STROBE_MAX = 10'h3FF;

	// operation classes handed from front to back
	typedef enum logic [2:0] {
		OP_NONE,
		OP_TICK,
		OP_DONE,
		OP_RIGHT_PRESS,
		OP_LEFT_PRESS,
		OP_LEFT_RELEASE
	} op_t;

	// strobe phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_OFF,
		PH_ON
	} phase_t;

	// one queue beat
	typedef struct packed {
		logic valid;
		op_t  op;
	} q_beat_t;

	// off time in ticks per pattern, zero for solid
	function automatic logic [9:0] off_time(input logic [2:0] pat);
		logic [9:0] t;
		unique case (pat)
			3'd1:    t = 10'd900;
			3'd2:    t = 10'd450;
			3'd3:    t = 10'd300;
			3'd4:    t = 10'd200;
			3'd5:    t = 10'd100;
			default: t = 10'd0;
		endcase
		return t;
	endfunction

	// on time in ticks per pattern, zero for solid
	function automatic logic [9:0] on_time(input logic [2:0] pat);
		logic [9:0] t;
		unique case (pat)
			3'd1:    t = 10'd100;
			3'd2:    t = 10'd30;
			3'd3:    t = 10'd20;
			3'd4:    t = 10'd10;
			3'd5:    t = 10'd10;
			default: t = 10'd0;
		endcase
		return t;
	endfunction

endpackage

// ----- hw/rtl/lsb_if.sv -----
// event and result channel interfaces
`timescale 1ns / 1ps

interface lsb_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [1:0] button;

	modport source (output valid, output action, output button, input ready);
	modport sink (input valid, input action, input button, output ready);
endinterface

interface lsb_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] led_level;
	logic       led_write;
	logic       morse_start;
	logic       busy_res;

	modport source (output valid, output led_level, output led_write, output morse_start,
		output busy_res, input ready);
	modport sink (input valid, input led_level, input led_write, input morse_start,
		input busy_res, output ready);
endinterface

// ----- hw/rtl/lsb_front.sv -----
// front end: takes event beats and classifies them into operations
`timescale 1ns / 1ps

module lsb_front (
	lsb_evt_if.sink          evt,
	output lsb_pkg::q_beat_t push,
	input  logic             push_ready
);

	lsb_pkg::op_t op;

	// decode action and button into one operation
	always_comb begin
		op = lsb_pkg::OP_NONE;
		unique case (evt.action)
			lsb_pkg::ACT_TICK: begin
				op = lsb_pkg::OP_TICK;
			end
			lsb_pkg::ACT_DONE: begin
				op = lsb_pkg::OP_DONE;
			end
			lsb_pkg::ACT_PRESS: begin
				if (evt.button == lsb_pkg::BTN_RIGHT) begin
					op = lsb_pkg::OP_RIGHT_PRESS;
				end else if (evt.button == lsb_pkg::BTN_LEFT) begin
					op = lsb_pkg::OP_LEFT_PRESS;
				end
			end
			lsb_pkg::ACT_RELEASE: begin
				if (evt.button == lsb_pkg::BTN_LEFT) begin
					op = lsb_pkg::OP_LEFT_RELEASE;
				end
			end
		endcase
	end

	// hand the beat to the queue
	assign push.valid = evt.valid;
	assign push.op    = op;
	assign evt.ready  = push_ready;

endmodule

// ----- hw/rtl/lsb_queue.sv -----
// small operation queue between front and back
`timescale 1ns / 1ps

module lsb_queue #(
	parameter int Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lsb_pkg::q_beat_t push,
	output logic             push_ready,
	output lsb_pkg::q_beat_t head,
	input  logic             pop
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	lsb_pkg::op_t    mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (cnt_q != CntW'(Depth));
	assign head.valid = (cnt_q != '0);
	assign head.op    = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && head.valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("queue fill count beyond depth");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> cnt_q == CntW'($past(cnt_q) + 1'b1))
		else $error("queue count missed a push");

	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> cnt_q == CntW'($past(cnt_q) - 1'b1))
		else $error("queue count missed a pop");

endmodule

// ----- hw/rtl/lsb_back.sv -----
// back end: button, hold and strobe state, config registers and result register
`timescale 1ns / 1ps

module lsb_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lsb_pkg::q_beat_t                head,
	output logic                            pop,
	input  logic                            cfg_we,
	input  logic [lsb_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [lsb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	lsb_res_if.source                       res
);

	// config registers
	logic [11:0] hold_ticks_q;
	logic [7:0]  level_high_q;
	logic [7:0]  level_mid_q;
	logic [7:0]  level_low_q;

	// block state
	logic [1:0]       bright_q, bright_d;
	logic [2:0]       pat_q, pat_d;
	logic             hold_run_q, hold_run_d;
	logic [11:0]      hold_cnt_q, hold_cnt_d;
	logic             busy_q, busy_d;
	lsb_pkg::phase_t  phase_q, phase_d;
	logic [9:0]       scnt_q, scnt_d;
	logic [7:0]       led_q, led_d;

	// result register
	logic       res_valid_q;
	logic [7:0] res_level_q;
	logic       res_write_q;
	logic       res_start_q;
	logic       res_busy_q;

	// helpers
	logic [11:0] hold_inc;
	logic [9:0]  scnt_inc;
	logic [9:0]  period;
	logic [2:0]  pat_nx;
	logic [1:0]  bright_nx;
	logic [2:0]  rst_pat;
	logic        rst_solid;
	logic        hold_fire;
	logic        wrote;
	logic        start;

	function automatic logic [7:0] pick_level(input logic [1:0] idx, input logic [7:0] hi,
		input logic [7:0] mid, input logic [7:0] lo);
		logic [7:0] v;
		unique case (idx)
			lsb_pkg::BRIGHT_HIGH: v = hi;
			lsb_pkg::BRIGHT_MID:  v = mid;
			default:              v = lo;
		endcase
		return v;
	endfunction

	// take the next operation once the result register is free
	assign pop = head.valid && (!res_valid_q || res.ready);

	// saturating counts, periods and wrapped indexes
	assign hold_inc  = (hold_cnt_q == lsb_pkg::HOLD_MAX) ? hold_cnt_q : hold_cnt_q + 12'd1;
	assign scnt_inc  = (scnt_q == lsb_pkg::STROBE_MAX) ? scnt_q : scnt_q + 10'd1;
	assign period    = (phase_q == lsb_pkg::PH_OFF) ? lsb_pkg::off_time(pat_q)
		: lsb_pkg::on_time(pat_q);
	assign pat_nx    = (pat_q == lsb_pkg::PATTERN_LAST) ? 3'd0 : pat_q + 3'd1;
	assign bright_nx = (bright_q == lsb_pkg::BRIGHT_LAST) ? 2'd0 : bright_q + 2'd1;
	assign hold_fire = hold_run_q && (hold_inc >= hold_ticks_q);
	assign rst_pat   = (head.op == lsb_pkg::OP_RIGHT_PRESS) ? pat_nx : pat_q;
	assign rst_solid = (lsb_pkg::off_time(rst_pat) == 10'd0);

	// next state for the operation at the queue head
	always_comb begin
		bright_d   = bright_q;
		pat_d      = pat_q;
		hold_run_d = hold_run_q;
		hold_cnt_d = hold_cnt_q;
		busy_d     = busy_q;
		phase_d    = phase_q;
		scnt_d     = scnt_q;
		led_d      = led_q;
		wrote      = 1'b0;
		start      = 1'b0;
		unique case (head.op)
			lsb_pkg::OP_TICK: begin
				if (hold_run_q) begin
					hold_cnt_d = hold_inc;
				end
				if (hold_fire) begin
					hold_run_d = 1'b0;
					phase_d    = lsb_pkg::PH_IDLE;
					scnt_d     = 10'd0;
					busy_d     = 1'b1;
					start      = 1'b1;
				end else if (phase_q == lsb_pkg::PH_OFF || phase_q == lsb_pkg::PH_ON) begin
					if (period == 10'd0) begin
						phase_d = lsb_pkg::PH_IDLE;
						scnt_d  = 10'd0;
					end else begin
						scnt_d = scnt_inc;
						if (scnt_inc >= period) begin
							scnt_d = 10'd0;
							wrote  = 1'b1;
							if (phase_q == lsb_pkg::PH_OFF) begin
								led_d   = pick_level(bright_q, level_high_q, level_mid_q,
									level_low_q);
								phase_d = lsb_pkg::PH_ON;
							end else begin
								led_d   = 8'd0;
								phase_d = lsb_pkg::PH_OFF;
							end
						end
					end
				end
			end
			lsb_pkg::OP_DONE, lsb_pkg::OP_RIGHT_PRESS: begin
				// strobe restart for the current or the next pattern
				if ((head.op == lsb_pkg::OP_DONE) == busy_q) begin
					pat_d  = rst_pat;
					busy_d = 1'b0;
					scnt_d = 10'd0;
					if (rst_solid) begin
						phase_d = lsb_pkg::PH_IDLE;
						led_d   = pick_level(bright_q, level_high_q, level_mid_q, level_low_q);
						wrote   = 1'b1;
					end else begin
						phase_d = lsb_pkg::PH_OFF;
					end
				end
			end
			lsb_pkg::OP_LEFT_PRESS: begin
				if (!busy_q) begin
					hold_run_d = 1'b1;
					hold_cnt_d = 12'd0;
				end
			end
			lsb_pkg::OP_LEFT_RELEASE: begin
				if (!busy_q && hold_run_q) begin
					hold_run_d = 1'b0;
					hold_cnt_d = 12'd0;
					bright_d   = bright_nx;
					if (lsb_pkg::off_time(pat_q) == 10'd0) begin
						led_d = pick_level(bright_nx, level_high_q, level_mid_q, level_low_q);
						wrote = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= lsb_pkg::HOLD_TICKS_RST;
			level_high_q <= lsb_pkg::LEVEL_HIGH_RST;
			level_mid_q  <= lsb_pkg::LEVEL_MID_RST;
			level_low_q  <= lsb_pkg::LEVEL_LOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				lsb_pkg::CFG_HOLD_TICKS: hold_ticks_q <= cfg_wdata;
				lsb_pkg::CFG_LEVEL_HIGH: level_high_q <= cfg_wdata[7:0];
				lsb_pkg::CFG_LEVEL_MID:  level_mid_q  <= cfg_wdata[7:0];
				lsb_pkg::CFG_LEVEL_LOW:  level_low_q  <= cfg_wdata[7:0];
			endcase
		end
	end

	// state update and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q    <= 2'd0;
			pat_q       <= 3'd0;
			hold_run_q  <= 1'b0;
			hold_cnt_q  <= 12'd0;
			busy_q      <= 1'b0;
			phase_q     <= lsb_pkg::PH_IDLE;
			scnt_q      <= 10'd0;
			led_q       <= lsb_pkg::LEVEL_HIGH_RST;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				bright_q    <= bright_d;
				pat_q       <= pat_d;
				hold_run_q  <= hold_run_d;
				hold_cnt_q  <= hold_cnt_d;
				busy_q      <= busy_d;
				phase_q     <= phase_d;
				scnt_q      <= scnt_d;
				led_q       <= led_d;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_level_q <= led_d;
			res_write_q <= wrote;
			res_start_q <= start;
			res_busy_q  <= busy_d;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.led_level   = res_level_q;
	assign res.led_write   = res_write_q;
	assign res.morse_start = res_start_q;
	assign res.busy_res    = res_busy_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |-> !pop)
		else $error("result beat overwritten while stalled");

	a_busy_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !hold_run_q)
		else $error("hold running during morse playback");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && start) |=> (res.valid && res.morse_start && res.busy_res))
		else $error("morse start beat not flagged busy");

endmodule

// ----- hw/rtl/led_strobe_button_controller.sv -----
// top level of the led strobe and button controller
//
//   channel  dir  handshake     payload
//   evt      in   valid/ready   action[1:0], button[1:0]
//   res      out  valid/ready   led_level[7:0], led_write, morse_start, busy_res
//   cfg      in   cfg_we        cfg_idx[1:0], cfg_wdata[11:0]
//
// one event beat per cycle sustained while the result side takes beats;
// each result beat is registered in the back end after its event beat
// passes the operation queue, which holds QueueDepth beats, so the event
// side keeps taking up to that many beats while the result side stalls
// arst_n clears control state and loads register defaults; no clearing pass
`timescale 1ns / 1ps

module led_strobe_button_controller #(
	parameter int QueueDepth = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lsb_evt_if.sink                        evt,
	lsb_res_if.source                      res,
	input  logic                           cfg_we,
	input  logic [lsb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lsb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	lsb_pkg::q_beat_t push;
	lsb_pkg::q_beat_t head;
	logic             push_ready;
	logic             pop;

	// classify incoming beats
	lsb_front u_front (
		.evt        (evt),
		.push       (push),
		.push_ready (push_ready)
	);

	// decouple front and back
	lsb_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	// carry out operations
	lsb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.res       (res)
	);

endmodule
